### rtl/core/btop_pkg.sv
// Shared types and constants for the binomial tree option pricer.
`default_nettype none

package btop_pkg;

  localparam int MAX_STEPS = 1024;
  localparam int DEPTH     = MAX_STEPS + 1;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int EXP_W     = 20;

  localparam logic [30:0] PROB_ONE   = 31'h4000_0000;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_2000_0000;
  localparam logic [31:0] MANT_ONE   = 32'h8000_0000;

  localparam logic signed [EXP_W-1:0] EXP_ZERO  = EXP_W'(0);
  localparam logic signed [EXP_W-1:0] EXP_ONE   = EXP_W'(1);
  localparam logic signed [EXP_W-1:0] EXP_Q16   = EXP_W'(16);
  localparam logic signed [EXP_W-1:0] EXP_32    = EXP_W'(32);
  localparam logic signed [EXP_W-1:0] EXP_31    = EXP_W'(31);
  localparam logic signed [EXP_W-1:0] EXP_SPOT  = EXP_W'(-16);
  localparam logic signed [EXP_W-1:0] EXP_FACT  = EXP_W'(-30);
  localparam logic signed [EXP_W-1:0] EXP_UNIT  = EXP_W'(-31);

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [31:0]             m;
    logic signed [EXP_W-1:0] e;
  } pfloat_t;

  typedef struct packed {
    pfloat_t a;
    pfloat_t b;
  } mul_req_t;

  typedef struct packed {
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic [31:0] up_factor;
    logic [31:0] down_factor;
    logic [30:0] up_probability;
    logic [30:0] step_discount;
    logic [10:0] step_count;
    logic        is_put;
    logic        is_american;
  } in_item_t;

  typedef struct packed {
    logic [31:0] option_price;
    logic        status;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM,
    ST_SPU,
    ST_UPM,
    ST_DNM,
    ST_SNX,
    ST_LRD,
    ST_LMU,
    ST_LWR,
    ST_FST,
    ST_FLO,
    ST_FRD,
    ST_FMP,
    ST_FMQ,
    ST_FMD,
    ST_FMT,
    ST_FAM,
    ST_FPX,
    ST_FWR,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### rtl/core/btop_if.sv
// Valid/ready channel interfaces for pricing jobs and results.
`default_nettype none

interface btop_in_if;
  logic               valid;
  logic               ready;
  btop_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface btop_out_if;
  logic                valid;
  logic                ready;
  btop_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### rtl/core/btop_mul.sv
// Shared registered 32x32 multiplier with pseudo-float normalisation of the product.
`default_nettype none

module btop_mul (
  input  wire logic               clk,
  input  wire btop_pkg::mul_req_t req,
  output logic [63:0]             prod,
  output btop_pkg::pfloat_t       res
);

  logic [63:0]                       prod_r;
  logic signed [btop_pkg::EXP_W-1:0] esum_r;
  logic                              zero_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(req.a.m) * 64'(req.b.m);
    esum_r <= req.a.e + req.b.e;
    zero_r <= (req.a.m == '0) || (req.b.m == '0);
  end

  assign prod = prod_r;

  always_comb begin
    if (zero_r) begin
      res.m = '0;
      res.e = btop_pkg::EXP_ZERO;
    end else if (prod_r[63]) begin
      res.m = prod_r[63:32];
      res.e = esum_r + btop_pkg::EXP_32;
    end else begin
      res.m = prod_r[62:31];
      res.e = esum_r + btop_pkg::EXP_31;
    end
  end

endmodule

`default_nettype wire

### rtl/core/binomial_tree_option_pricer_unit.sv
// Top level of the binomial tree option pricer: job sequencer, value stores and datapath.
`default_nettype none

// Prices one job at a time by backward induction over a binomial lattice of N steps.
// All multiplies go through one registered 32x32 multiplier, so the fold over the tree
// sets the rate: each node update is one read of the value store and of each power store
// and four multiplies, one of them for the early-exercise price, with an extra payoff
// step for an American option. The block takes no new job until the current one is
// finished; a finished result waits in the output register. Invalid jobs (zero spot,
// strike or step count, step count above the maximum, up probability above one) are
// answered with a zero price and the invalid status and leave the value store untouched.
module binomial_tree_option_pricer_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  btop_in_if.sink     in_ch,
  btop_out_if.source  out_ch
);

  localparam int IDX_W = btop_pkg::IDX_W;

  btop_pkg::state_t state_r, state_nxt;

  logic [31:0] strike_r;
  logic [30:0] p_r, q_r, disc_r;
  logic [10:0] n_r;
  logic        put_r, amer_r;

  btop_pkg::pfloat_t sp_r, uq_r, dq_r, upow_r, dpow_r;

  logic [IDX_W-1:0] node_r, lvl_r;

  logic [63:0] acc_r;
  logic [31:0] t_r, v_r, ex_r, vlo_r, vhi_r;
  logic [31:0] res_price_r;
  logic        res_status_r;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_price_r;
  logic        out_status_r;

  logic [31:0]       val_mem  [btop_pkg::DEPTH];
  btop_pkg::pfloat_t spu_mem  [btop_pkg::DEPTH];
  btop_pkg::pfloat_t dpow_mem [btop_pkg::DEPTH];
  logic [31:0]       val_rd_r;
  btop_pkg::pfloat_t spu_rd_r, dpow_rd_r;

  logic              val_we, val_re, spu_we, spu_re, dpow_we, dpow_re;
  logic [IDX_W-1:0]  val_wa, val_ra, spu_wa, spu_ra, dpow_wa, dpow_ra;
  logic [31:0]       val_wd;

  btop_pkg::mul_req_t mul_req;
  logic [63:0]        mul_prod;
  btop_pkg::pfloat_t  mul_res;

  logic        in_ok, norm_done, leaf_last, node_last;
  logic [63:0] mix_sum, disc_sum;
  logic [31:0] v_sat, px_payoff, node_val;

  function automatic logic [31:0] to_q16(input btop_pkg::pfloat_t a);
    logic signed [btop_pkg::EXP_W-1:0] s;
    logic signed [btop_pkg::EXP_W-1:0] sh;
    logic [31:0]                       r;
    s  = a.e + btop_pkg::EXP_Q16;
    sh = btop_pkg::EXP_ZERO - s;
    if (a.m == '0) begin
      r = '0;
    end else if (s > btop_pkg::EXP_ZERO) begin
      r = '1;
    end else if (s == btop_pkg::EXP_ZERO) begin
      r = a.m;
    end else if (sh >= btop_pkg::EXP_32) begin
      r = '0;
    end else begin
      r = a.m >> sh[4:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k,
                                         input logic put);
    logic [31:0] r;
    if (put) begin
      r = (k > s) ? k - s : '0;
    end else begin
      r = (s > k) ? s - k : '0;
    end
    return r;
  endfunction

  btop_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_prod),
    .res  (mul_res)
  );

  assign in_ok = (in_ch.item.spot_price != '0) && (in_ch.item.strike_price != '0) &&
                 (in_ch.item.step_count != '0) &&
                 (32'(in_ch.item.step_count) <= 32'(btop_pkg::MAX_STEPS)) &&
                 (in_ch.item.up_probability <= btop_pkg::PROB_ONE);

  assign norm_done = ((sp_r.m == '0) || sp_r.m[31]) &&
                     ((uq_r.m == '0) || uq_r.m[31]) &&
                     ((dq_r.m == '0) || dq_r.m[31]);

  assign leaf_last = (node_r == IDX_W'(n_r));
  assign node_last = (node_r == lvl_r - IDX_W'(1));

  // mix stays below 2^62, so bits 63:62 of the rounded sum are clear
  assign mix_sum   = acc_r + mul_prod + btop_pkg::ROUND_HALF;
  assign disc_sum  = mul_prod + btop_pkg::ROUND_HALF;
  assign v_sat     = (disc_sum[63:62] != 2'b00) ? '1 : disc_sum[61:30];
  assign px_payoff = payoff(to_q16(mul_res), strike_r, put_r);
  assign node_val  = (amer_r && (ex_r > v_r)) ? ex_r : v_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      btop_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ok ? btop_pkg::ST_NORM : btop_pkg::ST_FIN;
        end
      end
      btop_pkg::ST_NORM: begin
        if (norm_done) begin
          state_nxt = btop_pkg::ST_SPU;
        end
      end
      btop_pkg::ST_SPU: state_nxt = btop_pkg::ST_UPM;
      btop_pkg::ST_UPM: state_nxt = btop_pkg::ST_DNM;
      btop_pkg::ST_DNM: state_nxt = btop_pkg::ST_SNX;
      btop_pkg::ST_SNX: state_nxt = leaf_last ? btop_pkg::ST_LRD : btop_pkg::ST_SPU;
      btop_pkg::ST_LRD: state_nxt = btop_pkg::ST_LMU;
      btop_pkg::ST_LMU: state_nxt = btop_pkg::ST_LWR;
      btop_pkg::ST_LWR: state_nxt = leaf_last ? btop_pkg::ST_FST : btop_pkg::ST_LRD;
      btop_pkg::ST_FST: state_nxt = btop_pkg::ST_FLO;
      btop_pkg::ST_FLO: state_nxt = btop_pkg::ST_FRD;
      btop_pkg::ST_FRD: state_nxt = btop_pkg::ST_FMP;
      btop_pkg::ST_FMP: state_nxt = btop_pkg::ST_FMQ;
      btop_pkg::ST_FMQ: state_nxt = btop_pkg::ST_FMD;
      btop_pkg::ST_FMD: state_nxt = btop_pkg::ST_FMT;
      btop_pkg::ST_FMT: state_nxt = btop_pkg::ST_FAM;
      btop_pkg::ST_FAM: state_nxt = amer_r ? btop_pkg::ST_FPX : btop_pkg::ST_FWR;
      btop_pkg::ST_FPX: state_nxt = btop_pkg::ST_FWR;
      btop_pkg::ST_FWR: begin
        if (!node_last) begin
          state_nxt = btop_pkg::ST_FRD;
        end else if (lvl_r == IDX_W'(1)) begin
          state_nxt = btop_pkg::ST_FIN;
        end else begin
          state_nxt = btop_pkg::ST_FST;
        end
      end
      btop_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = btop_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btop_pkg::ST_IDLE;
    endcase
  end

  // control outputs: input ready, multiplier operands and store ports
  always_comb begin
    in_ch.ready = 1'b0;
    mul_req     = '0;
    val_we      = 1'b0;
    val_wa      = node_r;
    val_wd      = node_val;
    val_re      = 1'b0;
    val_ra      = node_r + IDX_W'(1);
    spu_we      = 1'b0;
    spu_wa      = node_r;
    spu_re      = 1'b0;
    spu_ra      = node_r;
    dpow_we     = 1'b0;
    dpow_wa     = node_r;
    dpow_re     = 1'b0;
    dpow_ra     = lvl_r - IDX_W'(1) - node_r;
    case (state_r)
      btop_pkg::ST_IDLE: in_ch.ready = 1'b1;
      btop_pkg::ST_SPU: begin
        mul_req.a = sp_r;
        mul_req.b = upow_r;
        dpow_we   = 1'b1;
      end
      btop_pkg::ST_UPM: begin
        mul_req.a = upow_r;
        mul_req.b = uq_r;
        spu_we    = 1'b1;
      end
      btop_pkg::ST_DNM: begin
        mul_req.a = dpow_r;
        mul_req.b = dq_r;
      end
      btop_pkg::ST_LRD: begin
        spu_re  = 1'b1;
        dpow_re = 1'b1;
        dpow_ra = IDX_W'(n_r) - node_r;
      end
      btop_pkg::ST_LMU: begin
        mul_req.a = spu_rd_r;
        mul_req.b = dpow_rd_r;
      end
      btop_pkg::ST_LWR: begin
        val_we = 1'b1;
        val_wd = px_payoff;
      end
      btop_pkg::ST_FST: begin
        val_re = 1'b1;
        val_ra = '0;
      end
      btop_pkg::ST_FRD: begin
        val_re  = 1'b1;
        spu_re  = 1'b1;
        dpow_re = 1'b1;
      end
      btop_pkg::ST_FMP: begin
        mul_req.a.m = {1'b0, p_r};
        mul_req.b.m = val_rd_r;
      end
      btop_pkg::ST_FMQ: begin
        mul_req.a.m = {1'b0, q_r};
        mul_req.b.m = vlo_r;
      end
      btop_pkg::ST_FMT: begin
        mul_req.a.m = t_r;
        mul_req.b.m = {1'b0, disc_r};
      end
      btop_pkg::ST_FAM: begin
        mul_req.a = spu_rd_r;
        mul_req.b = dpow_rd_r;
      end
      btop_pkg::ST_FWR: val_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (val_re) begin
      val_rd_r <= val_mem[val_ra];
    end
    if (spu_we) begin
      spu_mem[spu_wa] <= mul_res;
    end
    if (spu_re) begin
      spu_rd_r <= spu_mem[spu_ra];
    end
    if (dpow_we) begin
      dpow_mem[dpow_wa] <= dpow_r;
    end
    if (dpow_re) begin
      dpow_rd_r <= dpow_mem[dpow_ra];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      btop_pkg::ST_IDLE: begin
        strike_r     <= in_ch.item.strike_price;
        p_r          <= in_ch.item.up_probability;
        q_r          <= btop_pkg::PROB_ONE - in_ch.item.up_probability;
        disc_r       <= in_ch.item.step_discount;
        n_r          <= in_ch.item.step_count;
        put_r        <= in_ch.item.is_put;
        amer_r       <= in_ch.item.is_american;
        sp_r         <= '{m: in_ch.item.spot_price, e: btop_pkg::EXP_SPOT};
        uq_r         <= '{m: in_ch.item.up_factor, e: btop_pkg::EXP_FACT};
        dq_r         <= '{m: in_ch.item.down_factor, e: btop_pkg::EXP_FACT};
        res_price_r  <= '0;
        res_status_r <= btop_pkg::STATUS_INVALID;
      end
      btop_pkg::ST_NORM: begin
        if ((sp_r.m != '0) && !sp_r.m[31]) begin
          sp_r <= '{m: {sp_r.m[30:0], 1'b0}, e: sp_r.e - btop_pkg::EXP_ONE};
        end
        if ((uq_r.m != '0) && !uq_r.m[31]) begin
          uq_r <= '{m: {uq_r.m[30:0], 1'b0}, e: uq_r.e - btop_pkg::EXP_ONE};
        end
        if ((dq_r.m != '0) && !dq_r.m[31]) begin
          dq_r <= '{m: {dq_r.m[30:0], 1'b0}, e: dq_r.e - btop_pkg::EXP_ONE};
        end
        upow_r <= '{m: btop_pkg::MANT_ONE, e: btop_pkg::EXP_UNIT};
        dpow_r <= '{m: btop_pkg::MANT_ONE, e: btop_pkg::EXP_UNIT};
        node_r <= '0;
      end
      btop_pkg::ST_DNM: upow_r <= mul_res;
      btop_pkg::ST_SNX: begin
        dpow_r <= mul_res;
        node_r <= leaf_last ? '0 : node_r + IDX_W'(1);
      end
      btop_pkg::ST_LWR: begin
        if (leaf_last) begin
          lvl_r <= IDX_W'(n_r);
        end else begin
          node_r <= node_r + IDX_W'(1);
        end
      end
      btop_pkg::ST_FST: node_r <= '0;
      btop_pkg::ST_FLO: vlo_r <= val_rd_r;
      btop_pkg::ST_FMP: vhi_r <= val_rd_r;
      btop_pkg::ST_FMQ: acc_r <= mul_prod;
      btop_pkg::ST_FMD: t_r <= mix_sum[61:30];
      btop_pkg::ST_FAM: v_r <= v_sat;
      btop_pkg::ST_FPX: ex_r <= px_payoff;
      btop_pkg::ST_FWR: begin
        vlo_r <= vhi_r;
        if (!node_last) begin
          node_r <= node_r + IDX_W'(1);
        end else if (lvl_r == IDX_W'(1)) begin
          res_price_r  <= node_val;
          res_status_r <= btop_pkg::STATUS_OK;
        end else begin
          lvl_r <= lvl_r - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result register, loaded once the previous result has been transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == btop_pkg::ST_FIN) && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == btop_pkg::ST_FIN) && (!out_valid_r || out_ch.ready)) begin
      out_price_r  <= res_price_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btop_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.item.option_price = out_price_r;
  assign out_ch.item.status       = out_status_r;

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the binomial tree option pricer: directed and random jobs.
`timescale 1ns / 1ps

module tb;

  localparam int          RESET_CYCLES = 9;
  localparam int          RANDOM_JOBS  = 80;
  localparam int          TAIL_CYCLES  = 64;
  localparam int          QUIET_LIMIT  = 20_000_000;

  localparam logic [31:0] SPOT_100  = 32'h0064_0000;
  localparam logic [31:0] UP_1P1    = 32'h4666_6666;
  localparam logic [31:0] DN_0P9    = 32'h3A2E_8BA2;
  localparam logic [30:0] P_HALF    = 31'h2000_0000;
  localparam logic [30:0] DISC_NEAR = 31'h3FF0_0000;
  localparam logic [30:0] DISC_MAX  = 31'h7FFF_FFFF;

  typedef struct {
    logic [31:0] m;
    int          e;
  } mant_exp_t;

  logic clk = 1'b0;
  logic rst_n;

  btop_in_if  in_ch ();
  btop_out_if out_ch ();

  binomial_tree_option_pricer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  btop_pkg::out_item_t pending_prices[$];
  btop_pkg::out_item_t want;
  logic [31:0] lattice_val [0:btop_pkg::MAX_STEPS];
  mant_exp_t   up_pow      [0:btop_pkg::MAX_STEPS];
  mant_exp_t   down_pow    [0:btop_pkg::MAX_STEPS];

  int errors       = 0;
  int jobs_sent    = 0;
  int results_seen = 0;
  int invalid_seen = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;
  int stall_mode   = 0;
  int stall_left   = 0;

  // ---------------------------------------------------------------- predictor

  function automatic mant_exp_t to_pf(logic [31:0] x, int frac);
    mant_exp_t r;
    int        n;
    r.m = '0;
    r.e = 0;
    n   = 0;
    if (x == '0) return r;
    while (x[31] == 1'b0) begin
      x = x << 1;
      n++;
    end
    r.m = x;
    r.e = -frac - n;
    return r;
  endfunction

  function automatic mant_exp_t pf_mul(mant_exp_t a, mant_exp_t b);
    mant_exp_t   r;
    logic [63:0] p;
    r.m = '0;
    r.e = 0;
    if (a.m == '0 || b.m == '0) return r;
    p = {32'b0, a.m} * {32'b0, b.m};
    if (p[63]) begin
      r.m = p[63:32];
      r.e = a.e + b.e + 32;
    end else begin
      r.m = p[62:31];
      r.e = a.e + b.e + 31;
    end
    return r;
  endfunction

  function automatic logic [31:0] to_q16(mant_exp_t a);
    int s;
    s = a.e + 16;
    if (a.m == '0) return '0;
    if (s > 0) return 32'hFFFF_FFFF;
    if (s == 0) return a.m;
    if (-s >= 32) return '0;
    return a.m >> (-s);
  endfunction

  function automatic logic [31:0] intrinsic_value(logic [31:0] s, logic [31:0] k, logic put);
    if (put) return (k > s) ? k - s : '0;
    return (s > k) ? s - k : '0;
  endfunction

  function automatic logic [31:0] node_price(mant_exp_t sp, int level, int j);
    return to_q16(pf_mul(pf_mul(sp, up_pow[j]), down_pow[level - j]));
  endfunction

  function automatic btop_pkg::out_item_t price_job(btop_pkg::in_item_t job);
    btop_pkg::out_item_t r;
    mant_exp_t   sp, uq, dq;
    logic [63:0] p, q, disc, mix, t, v;
    logic [31:0] ex;
    int          n;
    r.option_price = '0;
    r.status       = btop_pkg::STATUS_INVALID;
    if (job.spot_price == '0 || job.strike_price == '0 || job.step_count == '0 ||
        job.step_count > btop_pkg::MAX_STEPS || job.up_probability > btop_pkg::PROB_ONE)
      return r;
    n    = int'(job.step_count);
    p    = {33'b0, job.up_probability};
    q    = {33'b0, btop_pkg::PROB_ONE} - p;
    disc = {33'b0, job.step_discount};
    sp   = to_pf(job.spot_price, 16);
    uq   = to_pf(job.up_factor, 30);
    dq   = to_pf(job.down_factor, 30);
    up_pow[0].m = btop_pkg::MANT_ONE;
    up_pow[0].e = -31;
    down_pow[0] = up_pow[0];
    for (int i = 1; i <= n; i++) begin
      up_pow[i]   = pf_mul(up_pow[i - 1], uq);
      down_pow[i] = pf_mul(down_pow[i - 1], dq);
    end
    for (int j = 0; j <= n; j++)
      lattice_val[j] = intrinsic_value(node_price(sp, n, j), job.strike_price, job.is_put);
    for (int lvl = n; lvl >= 1; lvl--) begin
      for (int j = 0; j < lvl; j++) begin
        mix = p * lattice_val[j + 1] + q * lattice_val[j];
        t   = (mix + btop_pkg::ROUND_HALF) >> 30;
        v   = (t * disc + btop_pkg::ROUND_HALF) >> 30;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        if (job.is_american) begin
          ex = intrinsic_value(node_price(sp, lvl - 1, j), job.strike_price, job.is_put);
          if ({32'b0, ex} > v) v = {32'b0, ex};
        end
        lattice_val[j] = v[31:0];
      end
    end
    r.option_price = lattice_val[0];
    r.status       = btop_pkg::STATUS_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------- job sender

  function automatic btop_pkg::in_item_t make_job(logic [31:0] spot, logic [31:0] strike,
                                                  logic [31:0] up, logic [31:0] dn,
                                                  logic [30:0] p, logic [30:0] disc,
                                                  logic [10:0] n, logic put, logic amer);
    btop_pkg::in_item_t j;
    j.spot_price     = spot;
    j.strike_price   = strike;
    j.up_factor      = up;
    j.down_factor    = dn;
    j.up_probability = p;
    j.step_discount  = disc;
    j.step_count     = n;
    j.is_put         = put;
    j.is_american    = amer;
    return j;
  endfunction

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 5);
    end
  endtask

  // called just after a falling edge; returns just after a falling edge
  task automatic send_job(btop_pkg::in_item_t job);
    in_ch.item  <= job;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_prices.push_back(price_job(job));
    jobs_sent++;
    @(negedge clk);
    pace_sender();
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    wait (pending_prices.size() == 0);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_basic_shapes();
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd1,
                      1'b0, 1'b0));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd2,
                      1'b1, 1'b0));
    send_job(make_job(SPOT_100, 32'h005A_0000, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd4,
                      1'b0, 1'b1));
    send_job(make_job(SPOT_100, 32'h006E_0000, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd5,
                      1'b1, 1'b1));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, '0, DISC_NEAR, 11'd3,
                      1'b0, 1'b1));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, btop_pkg::PROB_ONE, DISC_NEAR,
                      11'd3, 1'b1, 1'b1));
  endtask

  task automatic test_field_extremes();
    send_job(make_job(32'hFFFF_FFFF, 32'h1, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd2,
                      1'b0, 1'b0));
    send_job(make_job(32'h1, 32'hFFFF_FFFF, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd3,
                      1'b1, 1'b1));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, P_HALF, '0, 11'd3, 1'b1, 1'b0));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, P_HALF, btop_pkg::PROB_ONE,
                      11'd3, 1'b0, 1'b0));
    // discount above one, driven into saturation
    send_job(make_job(32'hF000_0000, 32'h1, UP_1P1, DN_0P9, P_HALF, DISC_MAX, 11'd4,
                      1'b0, 1'b0));
    // zero factors
    send_job(make_job(SPOT_100, SPOT_100, '0, DN_0P9, P_HALF, DISC_NEAR, 11'd3, 1'b1, 1'b1));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, '0, P_HALF, DISC_NEAR, 11'd3, 1'b0, 1'b1));
    // huge and tiny factors
    send_job(make_job(SPOT_100, SPOT_100, 32'hFFFF_FFFF, 32'h1, P_HALF, DISC_NEAR, 11'd6,
                      1'b0, 1'b1));
    send_job(make_job(SPOT_100, SPOT_100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, P_HALF, DISC_NEAR,
                      11'd8, 1'b1, 1'b1));
  endtask

  task automatic test_invalid_jobs();
    send_job(make_job('0, SPOT_100, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd3, 1'b0, 1'b0));
    send_job(make_job(SPOT_100, '0, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd3, 1'b1, 1'b1));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'd0,
                      1'b0, 1'b1));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, P_HALF, DISC_NEAR,
                      11'(btop_pkg::MAX_STEPS + 1), 1'b1, 1'b0));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, P_HALF, DISC_NEAR, 11'h7FF,
                      1'b0, 1'b0));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, btop_pkg::PROB_ONE + 31'd1,
                      DISC_NEAR, 11'd3, 1'b1, 1'b0));
    send_job(make_job(SPOT_100, SPOT_100, UP_1P1, DN_0P9, 31'h7FFF_FFFF, DISC_NEAR, 11'd3,
                      1'b0, 1'b1));
  endtask

  // full-size lattice, sent into an empty pipe
  task automatic test_max_steps();
    hold_until_drained();
    send_job(make_job(SPOT_100, SPOT_100, 32'h4051_EB85, 32'h3FAE_6B3F, P_HALF, 31'h3FFF_F000,
                      11'(btop_pkg::MAX_STEPS), 1'b1, 1'b0));
    hold_until_drained();
  endtask

  function automatic btop_pkg::in_item_t random_job();
    btop_pkg::in_item_t j;
    int                 kind;
    kind = $urandom_range(0, 99);
    j    = make_job($urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                    11'($urandom), 1'($urandom), 1'($urandom));
    if (kind < 70) begin
      j.spot_price     = $urandom_range(32'h0014_0000, 32'h00C8_0000);
      j.strike_price   = $urandom_range(j.spot_price / 2, j.spot_price * 3 / 2);
      j.up_factor      = 32'h4000_0000 + $urandom_range(0, 32'h0CCC_CCCC);
      j.down_factor    = 32'h4000_0000 - $urandom_range(0, 32'h0CCC_CCCC);
      j.up_probability = 31'($urandom_range(32'h1800_0000, 32'h2800_0000));
      j.step_discount  = 31'(32'h4000_0000 - $urandom_range(0, 32'h0100_0000));
      j.step_count     = 11'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(1, 12));
    end else if (kind < 85) begin
      if (j.spot_price == '0) j.spot_price = 32'h1;
      if (j.strike_price == '0) j.strike_price = 32'h1;
      j.up_probability = 31'($urandom_range(0, 32'(btop_pkg::PROB_ONE)));
      j.step_count     = 11'($urandom_range(1, 10));
    end else begin
      case ($urandom_range(0, 4))
        0:       j.spot_price = '0;
        1:       j.strike_price = '0;
        2:       j.step_count = '0;
        3:       j.step_count = 11'($urandom_range(btop_pkg::MAX_STEPS + 1, 2047));
        default: j.up_probability = 31'($urandom_range(32'(btop_pkg::PROB_ONE) + 32'd1,
                                                       32'h7FFF_FFFF));
      endcase
    end
    return j;
  endfunction

  task automatic test_random_jobs();
    for (int i = 0; i < RANDOM_JOBS; i++)
      send_job(random_job());
  endtask

  // ---------------------------------------------------------------- receiver and checks

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      2:       out_ch.ready <= (stall_left % 5 != 0);
      default: out_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
    $display("tb: mismatch on %s: got %h, want %h (result %0d)", what, got, wanted,
             results_seen);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_prices.size() == 0) begin
        report_mismatch("result with no job pending", out_ch.item.option_price, '0);
      end else begin
        want = pending_prices.pop_front();
        if (out_ch.item.status !== want.status)
          report_mismatch("status", 32'(out_ch.item.status), 32'(want.status));
        if (out_ch.item.option_price !== want.option_price)
          report_mismatch("option_price", out_ch.item.option_price, want.option_price);
        if (want.status == btop_pkg::STATUS_INVALID) invalid_seen++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
               pending_prices.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_shapes();
    test_field_extremes();
    test_invalid_jobs();
    test_max_steps();
    test_random_jobs();

    in_ch.valid <= 1'b0;
    wait (pending_prices.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d jobs priced, %0d results checked, %0d of them flagged invalid",
             jobs_sent, results_seen, invalid_seen);
    $display("tb: lattices of 1 to %0d steps, calls and puts, European and American",
             btop_pkg::MAX_STEPS);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
